@@ hdl/zip_unshrink_decoder_defines.svh @@
// assertion macros for the zip unshrink decoder checker
// expects signals named clock and reset in the scope of use
`ifndef ZIP_UNSHRINK_DECODER_DEFINES_SVH
`define ZIP_UNSHRINK_DECODER_DEFINES_SVH

// same-cycle implication
`define ZUD_CHECK(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zud check failed");

// next-cycle implication
`define ZUD_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("zud check failed");

`endif

@@ hdl/zud_pkg.sv @@
// shared constants of the zip unshrink decoder
// no dependencies
`default_nettype none

package zud_pkg;

   localparam int STOP_CODE      = 256;
   localparam int FIRST_FREE     = 257;
   localparam int INIT_CODE_BITS = 9;
   localparam int CSR_LEN_W      = 30;

   localparam logic CMD_FEED  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   localparam int SUB_WIDEN = 1;
   localparam int SUB_CLEAR = 2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_REFUSED = 2'd1;
   localparam status_type STATUS_EMPTY   = 2'd2;
   localparam status_type STATUS_ERROR   = 2'd3;

endpackage

`default_nettype wire

@@ hdl/zud_unpack.sv @@
// lsb-first code unpacker: bit buffer and variable-width code extraction
// depends on nothing but its parameter
`default_nettype none

module zud_unpack #(
   parameter int MAX_CODE_BITS = 13
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      shift_en,
   input  logic [7:0]                                in_byte,
   input  logic [$clog2(MAX_CODE_BITS + 2)-1:0]      code_width,
   output logic                                      code_ready,
   output logic [MAX_CODE_BITS-1:0]                  code
);

   localparam int BW  = MAX_CODE_BITS + 8;
   localparam int HW  = $clog2(BW + 1);

   logic [BW-1:0] buf_ff, buf_in, merged;
   logic [HW-1:0] held_ff, held_in, held_sum;

   always_comb begin
      merged     = buf_ff | (BW'(in_byte) << held_ff);
      held_sum   = held_ff + HW'(8);
      code_ready = 32'(held_sum) >= 32'(code_width);
      for (int k = 0; k < MAX_CODE_BITS; k++) begin
         code[k] = (32'(k) < 32'(code_width)) & merged[k];
      end
      buf_in  = buf_ff;
      held_in = held_ff;
      if (shift_en) begin
         if (code_ready) begin
            buf_in  = merged >> code_width;
            held_in = held_sum - HW'(code_width);
         end else begin
            buf_in  = merged;
            held_in = held_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         held_ff <= '0;
      end else begin
         buf_ff  <= buf_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/zip_unshrink_decoder.sv @@
// zip unshrink (lzw, method 1) decoder top level
// depends on zud_pkg and zud_unpack
`default_nettype none

// Decodes a zip shrink stream. Each request beat is either a feed of one compressed
// byte or a fetch of one decoded byte, and gives exactly one response beat. A feed
// that completes a data code walks the parent chain of the dictionary through the
// single read port of the table memory, one chain byte per cycle, then probes for
// the next free slot. A partial clear command sweeps the used part of the table in
// a marking pass and a freeing pass. A fetch reads through the pending-byte stack
// memory. After reset the block writes the initial dictionary (roots and free marks)
// and takes no request beat meanwhile; the length register may be written at any
// time the block is idle. The response register lets a new request in while a
// response beat still waits on rsp_stall. Any fault makes the error sticky until
// reset.
module zip_unshrink_decoder #(
   parameter int MAX_CODE_BITS = 13,
   parameter int TABLE_SIZE    = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_in_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output zud_pkg::status_type         rsp_status,
   output logic                        rsp_done_res,
   input  logic                        csr_wr_en,
   input  logic [zud_pkg::CSR_LEN_W-1:0] csr_wr_data
);

   import zud_pkg::*;

   localparam int AW  = $clog2(TABLE_SIZE);
   localparam int EW  = AW + 10;          // free, child, parent, byte
   localparam int CWW = $clog2(MAX_CODE_BITS + 2);
   localparam logic [AW:0]   TS_CNT = (AW + 1)'(TABLE_SIZE);
   localparam logic [AW-1:0] STOP_A = AW'(STOP_CODE);
   localparam int FREE_B  = EW - 1;
   localparam int CHILD_B = EW - 2;

   // sequencer codes
   localparam logic [3:0] ST_INIT     = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_FETCH    = 4'd2;
   localparam logic [3:0] ST_DECODE   = 4'd3;
   localparam logic [3:0] ST_WALK     = 4'd4;
   localparam logic [3:0] ST_WALK_END = 4'd5;
   localparam logic [3:0] ST_SLOT_CHK = 4'd6;
   localparam logic [3:0] ST_SLOT_GOT = 4'd7;
   localparam logic [3:0] ST_C1_CHK   = 4'd8;
   localparam logic [3:0] ST_C1_GOT   = 4'd9;
   localparam logic [3:0] ST_C1_PAR   = 4'd10;
   localparam logic [3:0] ST_C2_CHK   = 4'd11;
   localparam logic [3:0] ST_C2_GOT   = 4'd12;
   localparam logic [3:0] ST_FINISH   = 4'd13;
   localparam logic [3:0] ST_RESP     = 4'd14;

   // dictionary memory: one entry per code
   logic [EW-1:0] tbl_ff [TABLE_SIZE];
   logic [EW-1:0] tbl_rd_ff;
   logic          tbl_we;
   logic [AW-1:0] tbl_wa, tbl_ra;
   logic [EW-1:0] tbl_wd;

   // pending-byte stack memory
   logic [7:0]    stk_ff [TABLE_SIZE];
   logic [7:0]    stk_rd_ff;
   logic          stk_we;
   logic [AW-1:0] stk_wa, stk_ra;
   logic [7:0]    stk_wd;

   logic [3:0]               st_ff, st_in;
   logic [AW-1:0]            init_ff, init_in;
   logic [CSR_LEN_W-1:0]     len_ff, len_in;
   logic [AW:0]              pending_ff, pending_in;
   logic [CSR_LEN_W-1:0]     produced_ff, produced_in;
   logic [CWW-1:0]           cw_ff, cw_in;
   logic [AW-1:0]            prev_ff, prev_in;
   logic [7:0]               fbl_ff, fbl_in;
   logic [AW-1:0]            last_slot_ff, last_slot_in;
   logic                     await_ff, await_in;
   logic                     started_ff, started_in;
   logic                     err_ff, err_in;
   logic                     last_ff, last_in;
   logic [MAX_CODE_BITS-1:0] code_ff, code_in;
   logic [AW-1:0]            walk_ff, walk_in;
   logic [AW:0]              cnt_ff, cnt_in;
   logic [AW:0]              idx_ff, idx_in;
   logic [7:0]               push_ff, push_in;
   status_type               res_status_ff, res_status_in;
   logic [7:0]               res_byte_ff, res_byte_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     accept, complete, shift_en, up_ready;
   logic [MAX_CODE_BITS-1:0] up_code;
   logic                     ent_free;
   logic [AW-1:0]            ent_par, walk_nxt;
   logic [7:0]               ent_byte, push_val;

   zud_unpack #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_unpack (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (shift_en),
      .in_byte    (req_in_byte),
      .code_width (cw_ff),
      .code_ready (up_ready),
      .code       (up_code)
   );

   assign req_stall    = (st_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign complete     = started_ff && (produced_ff == len_ff);
   assign shift_en     = accept && (req_cmd == CMD_FEED) && !err_ff
                         && (pending_ff == '0) && !complete;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_done_res = rsp_done_ff;

   // fields of the entry just read
   assign ent_free = tbl_rd_ff[FREE_B];
   assign ent_par  = tbl_rd_ff[AW+7:8];
   assign ent_byte = tbl_rd_ff[7:0];
   // free entry on the chain is the kwkwk case
   assign walk_nxt = ent_free ? prev_ff : ent_par;
   assign push_val = ent_free ? fbl_ff : ent_byte;

   always_comb begin
      st_in         = st_ff;
      init_in       = init_ff;
      len_in        = csr_wr_en ? csr_wr_data : len_ff;
      pending_in    = pending_ff;
      produced_in   = produced_ff;
      cw_in         = cw_ff;
      prev_in       = prev_ff;
      fbl_in        = fbl_ff;
      last_slot_in  = last_slot_ff;
      await_in      = await_ff;
      started_in    = started_ff;
      err_in        = err_ff;
      last_in       = last_ff;
      code_in       = code_ff;
      walk_in       = walk_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      push_in       = push_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      tbl_we        = 1'b0;
      tbl_wa        = '0;
      tbl_wd        = '0;
      tbl_ra        = '0;
      stk_we        = 1'b0;
      stk_wa        = '0;
      stk_wd        = '0;
      stk_ra        = '0;

      case (st_ff)
         ST_INIT: begin
            // initial dictionary: roots below 256, free above
            tbl_we = 1'b1;
            tbl_wa = init_ff;
            if (32'(init_ff) < STOP_CODE) begin
               tbl_wd = {2'b00, STOP_A, init_ff[7:0]};
            end else begin
               tbl_wd = EW'(1) << FREE_B;
            end
            init_in = init_ff + AW'(1);
            if (init_ff == AW'(TABLE_SIZE - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_byte_in = 8'd0;
               last_in     = req_in_last;
               if (err_ff) begin
                  res_status_in = STATUS_ERROR;
                  st_in         = ST_RESP;
               end else if (req_cmd == CMD_FEED) begin
                  if (pending_ff != '0) begin
                     res_status_in = STATUS_REFUSED;
                     st_in         = ST_RESP;
                  end else if (complete) begin
                     res_status_in = STATUS_OK;
                     st_in         = ST_RESP;
                  end else if (up_ready) begin
                     code_in = up_code;
                     st_in   = ST_DECODE;
                  end else begin
                     st_in = ST_FINISH;
                  end
               end else begin
                  if (pending_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     st_in         = ST_RESP;
                  end else begin
                     pending_in = pending_ff - (AW + 1)'(1);
                     stk_ra     = pending_in[AW-1:0];
                     st_in      = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            res_byte_in   = stk_rd_ff;
            res_status_in = STATUS_OK;
            st_in         = ST_RESP;
         end
         ST_DECODE: begin
            st_in = ST_FINISH;
            if (!started_ff) begin
               // first code is a plain literal
               if (32'(code_ff) >= STOP_CODE
                   || ({1'b0, produced_ff} + (CSR_LEN_W + 1)'(1)) > {1'b0, len_ff}) begin
                  err_in = 1'b1;
               end else begin
                  stk_we      = 1'b1;
                  stk_wa      = '0;
                  stk_wd      = code_ff[7:0];
                  pending_in  = (AW + 1)'(1);
                  produced_in = produced_ff + CSR_LEN_W'(1);
                  fbl_in      = code_ff[7:0];
                  prev_in     = AW'(code_ff);
                  started_in  = 1'b1;
               end
            end else if (await_ff) begin
               await_in = 1'b0;
               if (32'(code_ff) == SUB_WIDEN) begin
                  cw_in = cw_ff + CWW'(1);
                  if (32'(cw_ff) + 1 > MAX_CODE_BITS) begin
                     err_in = 1'b1;
                  end
               end else if (32'(code_ff) == SUB_CLEAR) begin
                  idx_in = (AW + 1)'(FIRST_FREE);
                  st_in  = ST_C1_CHK;
               end else begin
                  err_in = 1'b1;
               end
            end else if (32'(code_ff) == STOP_CODE) begin
               await_in = 1'b1;
            end else if (32'(code_ff) >= TABLE_SIZE) begin
               err_in = 1'b1;
            end else begin
               walk_in = AW'(code_ff);
               tbl_ra  = AW'(code_ff);
               cnt_in  = '0;
               st_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            // one chain link per cycle, bytes pushed last-first
            if (cnt_ff == TS_CNT) begin
               err_in = 1'b1;
               st_in  = ST_FINISH;
            end else begin
               stk_we  = 1'b1;
               stk_wa  = cnt_ff[AW-1:0];
               stk_wd  = push_val;
               push_in = push_val;
               cnt_in  = cnt_ff + (AW + 1)'(1);
               if (walk_nxt == STOP_A) begin
                  st_in = ST_WALK_END;
               end else begin
                  walk_in = walk_nxt;
                  tbl_ra  = walk_nxt;
               end
            end
         end
         ST_WALK_END: begin
            if (cnt_ff == '0
                || ({1'b0, produced_ff} + (CSR_LEN_W + 1)'(cnt_ff)) > {1'b0, len_ff}) begin
               err_in = 1'b1;
               st_in  = ST_FINISH;
            end else begin
               pending_in  = cnt_ff;
               produced_in = produced_ff + CSR_LEN_W'(cnt_ff);
               fbl_in      = push_ff;
               idx_in      = {1'b0, last_slot_ff} + (AW + 1)'(1);
               st_in       = ST_SLOT_CHK;
            end
         end
         ST_SLOT_CHK: begin
            if (idx_ff >= TS_CNT) begin
               err_in = 1'b1;
               st_in  = ST_FINISH;
            end else begin
               tbl_ra = idx_ff[AW-1:0];
               st_in  = ST_SLOT_GOT;
            end
         end
         ST_SLOT_GOT: begin
            if (ent_free) begin
               tbl_we       = 1'b1;
               tbl_wa       = idx_ff[AW-1:0];
               tbl_wd       = {2'b00, prev_ff, fbl_ff};
               last_slot_in = idx_ff[AW-1:0];
               prev_in      = AW'(code_ff);
               st_in        = ST_FINISH;
            end else begin
               idx_in = idx_ff + (AW + 1)'(1);
               st_in  = ST_SLOT_CHK;
            end
         end
         ST_C1_CHK: begin
            // clear pass one: mark every parent above the stop code that has a child
            if (idx_ff > {1'b0, last_slot_ff}) begin
               idx_in = (AW + 1)'(FIRST_FREE);
               st_in  = ST_C2_CHK;
            end else begin
               tbl_ra = idx_ff[AW-1:0];
               st_in  = ST_C1_GOT;
            end
         end
         ST_C1_GOT: begin
            idx_in = idx_ff + (AW + 1)'(1);
            if (!ent_free && 32'(ent_par) > STOP_CODE) begin
               walk_in = ent_par;
               tbl_ra  = ent_par;
               st_in   = ST_C1_PAR;
            end else begin
               st_in = ST_C1_CHK;
            end
         end
         ST_C1_PAR: begin
            tbl_we = 1'b1;
            tbl_wa = walk_ff;
            tbl_wd = tbl_rd_ff | (EW'(1) << CHILD_B);
            st_in  = ST_C1_CHK;
         end
         ST_C2_CHK: begin
            // clear pass two: free the leaves, drop the marks
            if (idx_ff > {1'b0, last_slot_ff}) begin
               last_slot_in = STOP_A;
               st_in        = ST_FINISH;
            end else begin
               tbl_ra = idx_ff[AW-1:0];
               st_in  = ST_C2_GOT;
            end
         end
         ST_C2_GOT: begin
            tbl_we = 1'b1;
            tbl_wa = idx_ff[AW-1:0];
            if (tbl_rd_ff[CHILD_B]) begin
               tbl_wd = tbl_rd_ff & ~(EW'(1) << CHILD_B);
            end else begin
               tbl_wd = EW'(1) << FREE_B;
            end
            idx_in = idx_ff + (AW + 1)'(1);
            st_in  = ST_C2_CHK;
         end
         ST_FINISH: begin
            // early end of stream
            if (last_ff && !err_ff && !complete) begin
               err_in = 1'b1;
            end
            res_status_in = err_in ? STATUS_ERROR : STATUS_OK;
            res_byte_in   = 8'd0;
            st_in         = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_byte_in   = (res_status_ff == STATUS_OK) ? res_byte_ff : 8'd0;
               rsp_done_in   = !err_ff && complete && (pending_ff == '0);
               st_in         = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_ff[tbl_wa] <= tbl_wd;
      end
      tbl_rd_ff <= tbl_ff[tbl_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_ff[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_ff[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_INIT;
         init_ff       <= '0;
         len_ff        <= '0;
         pending_ff    <= '0;
         produced_ff   <= '0;
         cw_ff         <= CWW'(INIT_CODE_BITS);
         prev_ff       <= '0;
         fbl_ff        <= '0;
         last_slot_ff  <= STOP_A;
         await_ff      <= 1'b0;
         started_ff    <= 1'b0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         init_ff       <= init_in;
         len_ff        <= len_in;
         pending_ff    <= pending_in;
         produced_ff   <= produced_in;
         cw_ff         <= cw_in;
         prev_ff       <= prev_in;
         fbl_ff        <= fbl_in;
         last_slot_ff  <= last_slot_in;
         await_ff      <= await_in;
         started_ff    <= started_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      code_ff       <= code_in;
      walk_ff       <= walk_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      push_ff       <= push_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

endmodule

`default_nettype wire

@@ hdl/zud_checker.sv @@
// port-level checks for the zip unshrink decoder, bound to the top level
// depends on zud_pkg and zip_unshrink_decoder_defines.svh
`default_nettype none
`include "zip_unshrink_decoder_defines.svh"

module zud_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [7:0]          rsp_out_byte,
   input zud_pkg::status_type rsp_status,
   input logic                rsp_done_res
);

   import zud_pkg::*;

   logic err_seen_ff;

   // error once shown stays
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_status == STATUS_ERROR) begin
         err_seen_ff <= 1'b1;
      end
   end

   `ZUD_CHECK(a_err_not_done, rsp_valid && rsp_status == STATUS_ERROR, !rsp_done_res)
   `ZUD_CHECK(a_byte_zero, rsp_valid && rsp_status != STATUS_OK, rsp_out_byte == 8'd0)
   `ZUD_CHECK(a_err_sticky, rsp_valid && err_seen_ff, rsp_status == STATUS_ERROR)
   `ZUD_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte))

endmodule

bind zip_unshrink_decoder zud_checker u_zud_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status),
   .rsp_done_res (rsp_done_res)
);

`default_nettype wire

@@ tb/zip_unshrink_decoder_tb.sv @@
// self-checking testbench for the zip unshrink decoder
// depends on zud_pkg and the zip_unshrink_decoder top level
`default_nettype none

module zip_unshrink_decoder_tb;

   import zud_pkg::*;

   localparam int          TABLE_SZ  = 8192;
   localparam int          MAX_BITS  = 13;
   localparam logic [17:0] FREE_MARK = 18'h10000;
   localparam int          SETTLE    = 40;
   localparam int          LONG_HOLD = 400;
   localparam int          RUN_ITEMS = 500;

   typedef enum {BEAT_ITEM, BEAT_CFG, BEAT_DRAIN, BEAT_HOLD, BEAT_QUIET} job_kind_type;

   typedef struct {
      job_kind_type kind;
      logic        cmd;
      logic [7:0]  in_byte;
      logic        in_last;
      logic [29:0] value;
   } job_type;

   typedef struct {
      logic [7:0] out_byte;
      status_type status;
      logic       done;
   } rsp_type;

   // dut ports, inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_FEED;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   status_type  rsp_status;
   logic        rsp_done_res;
   logic        csr_wr_en = 1'b0;
   logic [CSR_LEN_W-1:0] csr_wr_data = '0;

   zip_unshrink_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status), .rsp_done_res(rsp_done_res),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // three copies of the decoder state:
   // 0 follows the beats as generated, 1 follows the beats the dut takes,
   // 2 runs ahead at code level to plan which codes are legal
   logic [17:0] link_tab [3][TABLE_SZ];   // [15:0] parent, [16] free, [17] has child
   logic [7:0]  char_tab [3][TABLE_SZ];
   logic [7:0]  out_stack [3][TABLE_SZ];
   int unsigned out_len [3];
   int unsigned stacked [3];
   logic [31:0] bit_buf [3];
   int unsigned bit_cnt [3];
   int unsigned code_bits [3];
   int unsigned prev_code [3];
   logic [7:0]  tail_char [3];
   int unsigned top_slot [3];
   bit          want_sub [3];
   bit          begun [3];
   int unsigned emitted [3];
   bit          broken [3];

   job_type job_q [$];
   rsp_type predicted_beats [$];
   bit    code_stream [$];   // planned code bits not yet packed into bytes
   bit    carry_bits [$];    // pad bits already sent that open the next code
   int    forced_codes [$];  // -1 stands for the next free slot
   int    item_total = 0;
   int    fail_count = 0;
   bit    stim_done = 1'b0;
   bit    quiet_mode = 1'b0;
   logic  req_fired = 1'b0;
   logic  hold_req = 1'b0;

   function automatic void lzw_reset(int m);
      for (int i = 0; i < TABLE_SZ; i++) begin
         link_tab[m][i] = (i < 256) ? 18'(STOP_CODE) : FREE_MARK;
         char_tab[m][i] = (i < 256) ? 8'(i) : 8'd0;
         out_stack[m][i] = 8'd0;
      end
      out_len[m] = 0; stacked[m] = 0; bit_buf[m] = 0; bit_cnt[m] = 0;
      code_bits[m] = INIT_CODE_BITS; prev_code[m] = 0; tail_char[m] = 0;
      top_slot[m] = STOP_CODE; want_sub[m] = 0; begun[m] = 0;
      emitted[m] = 0; broken[m] = 0;
   endfunction

   function automatic bit lzw_complete(int m);
      return begun[m] && emitted[m] == out_len[m];
   endfunction

   function automatic int unsigned lzw_next_free(int m);
      int unsigned slot;
      slot = top_slot[m] + 1;
      while (slot < TABLE_SZ && !link_tab[m][slot][16]) slot++;
      return slot;
   endfunction

   // partial clear: mark every entry that is somebody's parent, free the rest
   function automatic void lzw_clear(int m);
      int unsigned p;
      for (int unsigned i = FIRST_FREE; i <= top_slot[m] && i < TABLE_SZ; i++) begin
         p = link_tab[m][i][15:0];
         if (!link_tab[m][i][16] && p > STOP_CODE && p < TABLE_SZ) link_tab[m][p][17] = 1'b1;
      end
      for (int unsigned i = FIRST_FREE; i <= top_slot[m] && i < TABLE_SZ; i++) begin
         if (link_tab[m][i][17]) link_tab[m][i][17] = 1'b0;
         else link_tab[m][i] = FREE_MARK;
      end
      top_slot[m] = STOP_CODE;
   endfunction

   // length of the string a code stands for, or all ones on a fault
   function automatic int unsigned lzw_string_len(int m, int unsigned code);
      int unsigned walk, cnt;
      walk = code; cnt = 0;
      while (walk != STOP_CODE) begin
         if (walk >= TABLE_SZ || cnt >= TABLE_SZ) return 32'hFFFF_FFFF;
         cnt++;
         walk = link_tab[m][walk][16] ? prev_code[m] : int'(link_tab[m][walk][15:0]);
      end
      return cnt;
   endfunction

   function automatic void lzw_code(int m, int unsigned code);
      int unsigned walk, slot, cnt;
      cnt = 0;
      if (!begun[m]) begin
         if (code >= 256 || emitted[m] + 1 > out_len[m]) begin
            broken[m] = 1;
            return;
         end
         out_stack[m][0] = 8'(code); stacked[m] = 1; emitted[m] += 1;
         tail_char[m] = 8'(code); prev_code[m] = code; begun[m] = 1;
         return;
      end
      if (want_sub[m]) begin
         want_sub[m] = 0;
         if (code == SUB_WIDEN) begin
            code_bits[m]++;
            if (code_bits[m] > MAX_BITS) broken[m] = 1;
         end else if (code == SUB_CLEAR) lzw_clear(m);
         else broken[m] = 1;
         return;
      end
      if (code == STOP_CODE) begin
         want_sub[m] = 1;
         return;
      end
      if (code >= TABLE_SZ) begin
         broken[m] = 1;
         return;
      end
      // walk towards the root, the stack ends up in reverse output order
      walk = code;
      while (walk != STOP_CODE) begin
         if (walk >= TABLE_SZ || cnt >= TABLE_SZ) begin
            broken[m] = 1;
            return;
         end
         if (link_tab[m][walk][16]) begin
            out_stack[m][cnt] = tail_char[m];
            walk = prev_code[m];
         end else begin
            out_stack[m][cnt] = char_tab[m][walk];
            walk = link_tab[m][walk][15:0];
         end
         cnt++;
      end
      if (cnt == 0 || longint'(emitted[m]) + cnt > out_len[m]) begin
         broken[m] = 1;
         return;
      end
      stacked[m] = cnt; emitted[m] += cnt;
      tail_char[m] = out_stack[m][cnt-1];
      slot = lzw_next_free(m);
      if (slot >= TABLE_SZ) begin
         broken[m] = 1;
         return;
      end
      top_slot[m] = slot;
      char_tab[m][slot] = tail_char[m];
      link_tab[m][slot] = {2'b00, 16'(prev_code[m])};
      prev_code[m] = code;
   endfunction

   function automatic rsp_type lzw_step(int m, logic cmd, logic [7:0] b, logic last);
      rsp_type r;
      int unsigned code;
      r.out_byte = 8'd0; r.status = STATUS_OK;
      if (broken[m]) r.status = STATUS_ERROR;
      else if (cmd == CMD_FEED) begin
         if (stacked[m] > 0) r.status = STATUS_REFUSED;
         else if (!lzw_complete(m)) begin
            bit_buf[m] |= 32'(b) << bit_cnt[m];
            bit_cnt[m] += 8;
            if (bit_cnt[m] >= code_bits[m]) begin
               code = bit_buf[m] & ((32'd1 << code_bits[m]) - 1);
               bit_buf[m] >>= code_bits[m];
               bit_cnt[m] -= code_bits[m];
               lzw_code(m, code);
            end
            if (last && !broken[m] && !lzw_complete(m)) broken[m] = 1;
            r.status = broken[m] ? STATUS_ERROR : STATUS_OK;
         end
      end else begin
         if (stacked[m] == 0) r.status = STATUS_EMPTY;
         else begin
            stacked[m]--;
            r.out_byte = out_stack[m][stacked[m]];
         end
      end
      if (r.status == STATUS_ERROR) r.out_byte = 8'd0;
      r.done = !broken[m] && lzw_complete(m) && stacked[m] == 0;
      return r;
   endfunction

   // ---------------- stimulus building ----------------

   function automatic void add_item(logic cmd, logic [7:0] b, logic last);
      job_type j;
      rsp_type r;
      j.kind = BEAT_ITEM; j.cmd = cmd; j.in_byte = b; j.in_last = last; j.value = '0;
      job_q.insert(job_q.size(), j);
      r = lzw_step(0, cmd, b, last);
      item_total++;
   endfunction

   function automatic void add_job(job_kind_type kind, logic [29:0] value);
      job_type j;
      j.kind = kind; j.cmd = CMD_FEED; j.in_byte = 0; j.in_last = 0; j.value = value;
      job_q.insert(job_q.size(), j);
      if (kind == BEAT_CFG) begin
         out_len[0] = value;
         out_len[2] = value;
      end
   endfunction

   function automatic void push_code(int unsigned code);
      for (int i = 0; i < code_bits[2]; i++) code_stream.insert(code_stream.size(), code[i]);
      lzw_code(2, code);
   endfunction

   // the pad bits of the last stream already sit in the dut: open with a
   // literal whose low bits match them
   function automatic void start_phase();
      logic [7:0] lit;
      int n;
      if (carry_bits.size() == 0) return;
      lit = 8'($urandom);
      n = carry_bits.size();
      for (int i = 0; i < n; i++) lit[i] = carry_bits[i];
      push_code(lit);
      for (int i = 0; i < n; i++) void'(code_stream.pop_front());
      carry_bits.delete();
   endfunction

   // mostly legal codes: literals, live entries, kwkwk, the odd command pair
   function automatic void next_code();
      int unsigned room, c, r;
      if (forced_codes.size() > 0) begin
         c = forced_codes[0] < 0 ? lzw_next_free(2) : forced_codes[0];
         void'(forced_codes.pop_front());
         push_code(c);
         return;
      end
      room = out_len[2] - emitted[2];
      r = $urandom_range(0, 99);
      if (begun[2] && r < 5) begin
         push_code(STOP_CODE);
         if (code_bits[2] < MAX_BITS && $urandom_range(0, 1)) push_code(SUB_WIDEN);
         else push_code(SUB_CLEAR);
         return;
      end
      if (begun[2] && r >= 45 && r < 75 && top_slot[2] > STOP_CODE) begin
         c = $urandom_range(FIRST_FREE, top_slot[2]);
         if (!link_tab[2][c][16] && lzw_string_len(2, c) <= room) begin
            push_code(c);
            return;
         end
      end
      if (begun[2] && r >= 75 && r < 90) begin
         c = lzw_next_free(2);
         if (c < TABLE_SZ && lzw_string_len(2, c) <= room) begin
            push_code(c);
            return;
         end
      end
      push_code($urandom_range(0, 255));
   endfunction

   // one compressed byte, after fetching whatever is pending;
   // in_last goes on the byte that completes the final code
   function automatic void emit_byte(bit plan_done);
      logic [7:0] b;
      logic last;
      int n;
      while (stacked[0] > 0 && !broken[0]) begin
         if ($urandom_range(0, 9) == 0) add_item(CMD_FEED, 8'($urandom), 1'($urandom));
         add_item(CMD_FETCH, 8'($urandom), 1'($urandom));
      end
      last = plan_done && code_stream.size() <= 8 && bit_cnt[0] + 8 >= code_bits[0];
      b = 8'($urandom);
      n = 0;
      while (n < 8 && code_stream.size() > 0) begin
         b[n] = code_stream.pop_front();
         n++;
      end
      if (last) for (int k = n; k < 8; k++) carry_bits.insert(carry_bits.size(), b[k]);
      add_item(CMD_FEED, b, last);
   endfunction

   function automatic void run_stream(int unsigned len);
      add_job(BEAT_CFG, 30'(emitted[2] + len));
      start_phase();
      while (emitted[2] < out_len[2]) begin
         next_code();
         while (code_stream.size() >= 8) emit_byte(emitted[2] >= out_len[2]);
      end
      while (!lzw_complete(0) && !broken[0]) emit_byte(1'b1);
      while (stacked[0] > 0 && !broken[0]) add_item(CMD_FETCH, 8'($urandom), 1'($urandom));
      // stray beats once the stream is done: ignored feed, empty fetch
      if ($urandom_range(0, 3) == 0) add_item(CMD_FEED, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 3) == 0) add_item(CMD_FETCH, 8'($urandom), 1'($urandom));
   endfunction

   // the error is sticky, so exactly one fault closes the run
   function automatic void run_fault();
      int kind, guard;
      kind = $urandom_range(0, 3);
      add_job(BEAT_CFG, kind == 2 ? 30'd0 : 30'(emitted[2] + 1000));
      if (kind == 1) begin
         while (stacked[0] > 0 && !broken[0])
            add_item(CMD_FETCH, 8'($urandom), 1'($urandom));
         add_item(CMD_FEED, 8'($urandom), 1'b1);   // early end
      end else begin
         start_phase();
         if (kind == 2) push_code($urandom_range(0, 255));   // overrun of a zero length
         if (kind == 0) begin                                 // unknown command
            push_code(STOP_CODE);
            push_code(3);
         end
         if (kind == 3) begin                                 // widening past the limit
            while (code_bits[2] <= MAX_BITS) begin
               push_code(STOP_CODE);
               push_code(SUB_WIDEN);
            end
         end
         guard = 0;
         while (!broken[0] && guard < 40) begin
            emit_byte(1'b0);
            guard++;
         end
      end
      for (int i = 0; i < 4; i++) add_item(1'($urandom), 8'($urandom), 1'($urandom));
   endfunction

   // ---------------- driver ----------------

   int  gap_left = 0;
   int  settle_left = 0;
   bit  settle_armed = 1'b0;

   always @(negedge clock) begin
      job_type j;
      logic nv, nwr, nhold;
      nv = req_valid; nwr = 1'b0; nhold = 1'b0;
      if (reset) nv = 1'b0;
      else if (req_valid && !req_fired) begin
         // beat still on offer, payload stays put
      end else begin
         nv = 1'b0;
         if (gap_left > 0) gap_left--;
         else if (job_q.size() == 0) stim_done = 1'b1;
         else case (job_q[0].kind)
            BEAT_ITEM: begin
               j = job_q.pop_front();
               nv = 1'b1;
               req_cmd <= j.cmd;
               req_in_byte <= j.in_byte;
               req_in_last <= j.in_last;
               if (!quiet_mode && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
            end
            BEAT_CFG: begin
               // register writes only once the block has gone quiet
               if (predicted_beats.size() == 0) begin
                  if (!settle_armed) begin
                     settle_armed = 1'b1;
                     settle_left = SETTLE;
                  end else if (settle_left > 0) settle_left--;
                  else begin
                     j = job_q.pop_front();
                     nwr = 1'b1;
                     csr_wr_data <= j.value;
                     settle_armed = 1'b0;
                  end
               end
            end
            BEAT_DRAIN: if (predicted_beats.size() == 0) void'(job_q.pop_front());
            BEAT_HOLD: begin
               void'(job_q.pop_front());
               nhold = 1'b1;
            end
            default: begin
               void'(job_q.pop_front());
               quiet_mode <= 1'b1;
            end
         endcase
      end
      req_valid <= nv;
      csr_wr_en <= nwr;
      hold_req <= nhold;
   end

   // ---------------- receiver stall ----------------

   int hold_left = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      logic s;
      if (hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         hold_left--;
         s = 1'b1;
      end else if (quiet_mode) s = 1'b0;
      else if (stall_left > 0) begin
         stall_left--;
         s = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         s = 1'b1;
      end else s = 1'b0;
      rsp_stall <= s;
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (csr_wr_en) out_len[1] = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (predicted_beats.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               e = predicted_beats.pop_front();
               if (rsp_out_byte !== e.out_byte) begin
                  $error("out_byte: expected %0d, got %0d", e.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_done_res !== e.done) begin
                  $error("done_res: expected %0d, got %0d", e.done, rsp_done_res);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            predicted_beats.insert(predicted_beats.size(),
                                   lzw_step(1, req_cmd, req_in_byte, req_in_last));
      end
      req_fired <= !reset && req_valid && !req_stall;
   end

   // ---------------- run control ----------------

   initial begin
      bit held_once, drained_once;
      held_once = 0; drained_once = 0;
      for (int m = 0; m < 3; m++) lzw_reset(m);

      // directed: empty fetch, a short stream with kwkwk, widen and clear,
      // then a large length and the largest one
      add_item(CMD_FETCH, 8'hFF, 1'b1);
      forced_codes = '{0, 255, -1, STOP_CODE, SUB_WIDEN, 7, STOP_CODE, SUB_CLEAR, 0};
      run_stream(6);
      add_job(BEAT_CFG, 30'd536870912);
      add_item(CMD_FETCH, 8'h00, 1'b0);
      add_job(BEAT_CFG, 30'h3FFF_FFFF);

      forever begin
         if (item_total >= RUN_ITEMS) break;
         if (!held_once && item_total > 150) begin
            add_job(BEAT_HOLD, '0);
            held_once = 1;
         end
         if (!drained_once && item_total > 300) begin
            add_job(BEAT_DRAIN, '0);
            drained_once = 1;
         end
         if (item_total > 430) add_job(BEAT_QUIET, '0);
         run_stream($urandom_range(0, 9) < 7 ? $urandom_range(1, 30) : $urandom_range(30, 150));
      end
      run_fault();

      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      while (!(stim_done && predicted_beats.size() == 0)) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
